>>> sv/y86_move_instruction_unit_core_defines.svh
// Assertion macros used by the core to check its own logic.
`ifndef Y86_MOVE_INSTRUCTION_UNIT_CORE_DEFINES_SVH
`define Y86_MOVE_INSTRUCTION_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define Y86MV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define Y86MV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/y86mv_pkg.sv
package y86mv_pkg;

   // Memory and register file geometry.
   localparam int MEM_BYTES  = 4096;
   localparam int MEM_ADDR_W = $clog2(MEM_BYTES);
   localparam int REG_COUNT  = 15;
   localparam int REG_IDX_W  = 4;
   localparam int PC_W       = 12;

   // Instruction codes (high nibble of the first instruction byte).
   localparam logic [3:0] ICODE_RRMOVQ = 4'd2;
   localparam logic [3:0] ICODE_IRMOVQ = 4'd3;
   localparam logic [3:0] ICODE_RMMOVQ = 4'd4;
   localparam logic [3:0] ICODE_MRMOVQ = 4'd5;

   // Instruction lengths in bytes.
   localparam logic [PC_W-1:0] LEN_SHORT = PC_W'(2);
   localparam logic [PC_W-1:0] LEN_LONG  = PC_W'(10);

   // Request opcodes.
   localparam logic OP_LOAD_BYTE = 1'b0;
   localparam logic OP_EXECUTE   = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_INS,
      STAT_ADR
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_MOVE,
      S_ADDR,
      S_CHECK,
      S_STORE_RD,
      S_STORE,
      S_LOAD
   } state_type;

   typedef struct packed {
      logic       op;
      logic [11:0] load_address;
      logic [7:0]  load_byte;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [11:0]        next_pc;
      logic               reg_written;
      logic [3:0]         dest_reg;
      logic               mem_written;
      logic signed [63:0] moved_value;
   } rsp_type;

   // Byte memory write port.
   typedef struct packed {
      logic                  we;
      logic [MEM_ADDR_W-1:0] addr;
      logic [7:0]            data;
   } mem_wr_type;

   // Register file write port.
   typedef struct packed {
      logic                 we;
      logic [REG_IDX_W-1:0] addr;
      logic [63:0]          data;
   } rf_wr_type;

   // Builds one response word.
   function automatic rsp_type make_rsp(status_type st, logic [PC_W-1:0] pc, logic rw,
                                        logic [3:0] dr, logic mw, logic [63:0] v);
      rsp_type r;
      r.status      = st;
      r.next_pc     = pc;
      r.reg_written = rw;
      r.dest_reg    = dr;
      r.mem_written = mw;
      r.moved_value = $signed(v);
      return r;
   endfunction

endpackage

>>> sv/y86mv_byte_ram.sv
module y86mv_byte_ram import y86mv_pkg::*; (
   input  logic                  clock,
   input  mem_wr_type            wr,
   input  logic [MEM_ADDR_W-1:0] rd_addr,
   output logic [7:0]            rd_data
);

   logic [7:0] mem [MEM_BYTES];
   logic [7:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/y86mv_reg_file.sv
module y86mv_reg_file import y86mv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  rf_wr_type            wr,
   input  logic [REG_IDX_W-1:0] rd_addr,
   output logic [63:0]          rd_data
);

   logic [63:0]          regs [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [63:0]          rd_data_ff;
   logic                 rd_valid_ff;

   // An entry that was never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.we) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= (rd_addr < REG_IDX_W'(REG_COUNT)) && valid_ff[rd_addr];
      end
   end

   // Storage and registered read data.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         regs[wr.addr] <= wr.data;
      end
      rd_data_ff <= regs[rd_addr];
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 64'd0;

endmodule

>>> sv/y86_move_instruction_unit_core.sv
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+------------------------------------
// request   | start, busy, req_data          | taken when start high, busy low
// response  | rsp_strobe, rsp_data           | one cycle per request, no back-pressure
//
// A byte load answers in the cycle after it is taken. An instruction fetches one
// byte per cycle through the byte memory port, the data bytes going through the
// same port. After reset the memory is swept to zero, one byte a cycle; busy stays
// high until the sweep ends. Memory accesses never overlap, so no forwarding.
`include "y86_move_instruction_unit_core_defines.svh"

module y86_move_instruction_unit_core import y86mv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   state_type             state_ff, state_in;
   logic [3:0]            idx_ff, idx_in;
   logic [3:0]            icode_ff, icode_in;
   logic [3:0]            ra_ff, ra_in;
   logic [3:0]            rb_ff, rb_in;
   logic [63:0]           valc_ff, valc_in;
   logic [63:0]           addr_ff, addr_in;
   logic [63:0]           val_ff, val_in;
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [MEM_ADDR_W-1:0] clr_ff, clr_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;

   mem_wr_type            mem_wr;
   logic [MEM_ADDR_W-1:0] mem_raddr;
   logic [7:0]            mem_rdata;
   rf_wr_type             rf_wr;
   logic [REG_IDX_W-1:0]  rf_raddr;
   logic [63:0]           rf_rdata;

   logic [63:0]           valc_shift;
   logic [63:0]           load_shift;
   logic [MEM_ADDR_W-1:0] fetch_addr;
   logic [MEM_ADDR_W-1:0] data_addr;
   logic [31:0]           insn_len;

   y86mv_byte_ram u_ram (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   y86mv_reg_file u_rf (
      .clock   (clock),
      .reset   (reset),
      .wr      (rf_wr),
      .rd_addr (rf_raddr),
      .rd_data (rf_rdata)
   );

   // Byte assembly for the constant and for loaded data, little-endian.
   assign valc_shift = {mem_rdata, valc_ff[63:8]};
   assign load_shift = {mem_rdata, val_ff[63:8]};
   assign fetch_addr = MEM_ADDR_W'(pc_ff) + MEM_ADDR_W'(idx_ff);
   assign data_addr  = MEM_ADDR_W'(addr_ff) + MEM_ADDR_W'(idx_ff);
   assign insn_len   = (mem_rdata[7:4] == ICODE_RRMOVQ) ? 32'(LEN_SHORT) : 32'(LEN_LONG);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         pc_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pc_ff         <= pc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      icode_ff <= icode_in;
      ra_ff    <= ra_in;
      rb_ff    <= rb_in;
      valc_ff  <= valc_in;
      addr_ff  <= addr_in;
      val_ff   <= val_in;
      rsp_ff   <= rsp_in;
   end

   // Sequencer: next state, memory and register file ports, response.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      icode_in      = icode_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      valc_in       = valc_ff;
      addr_in       = addr_ff;
      val_in        = val_ff;
      pc_in         = pc_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_wr        = '0;
      mem_raddr     = fetch_addr + MEM_ADDR_W'(1);
      rf_wr         = '0;
      rf_raddr      = ra_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_wr.we   = 1'b1;
            mem_wr.addr = clr_ff;
            mem_wr.data = 8'd0;
            clr_in      = clr_ff + MEM_ADDR_W'(1);
            if (clr_ff == MEM_ADDR_W'(MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            mem_raddr = MEM_ADDR_W'(pc_ff);
            if (start) begin
               if (req_data.op == OP_LOAD_BYTE) begin
                  rsp_strobe_in = 1'b1;
                  if (32'(req_data.load_address) >= 32'(MEM_BYTES)) begin
                     rsp_in = make_rsp(STAT_ADR, pc_ff, 1'b0, 4'd0, 1'b0, 64'd0);
                  end else begin
                     mem_wr.we   = 1'b1;
                     mem_wr.addr = MEM_ADDR_W'(req_data.load_address);
                     mem_wr.data = req_data.load_byte;
                     rsp_in = make_rsp(STAT_OK, pc_ff, 1'b0, 4'd0, 1'b0, 64'd0);
                  end
               end else if (32'(pc_ff) >= 32'(MEM_BYTES)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = make_rsp(STAT_ADR, pc_ff, 1'b0, 4'd0, 1'b0, 64'd0);
               end else begin
                  idx_in   = 4'd0;
                  state_in = S_FETCH;
               end
            end
         end

         // Byte idx of the instruction is on the read port; the next is prefetched.
         S_FETCH: begin
            case (idx_ff)
               4'd0: begin
                  icode_in = mem_rdata[7:4];
                  if (!(mem_rdata[7:4] inside {[ICODE_RRMOVQ:ICODE_MRMOVQ]})) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in   = make_rsp(STAT_INS, pc_ff, 1'b0, 4'd0, 1'b0, 64'd0);
                     state_in = S_IDLE;
                  end else if (32'(pc_ff) + insn_len > 32'(MEM_BYTES)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in   = make_rsp(STAT_ADR, pc_ff, 1'b0, 4'd0, 1'b0, 64'd0);
                     state_in = S_IDLE;
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
               4'd1: begin
                  ra_in = mem_rdata[7:4];
                  rb_in = mem_rdata[3:0];
                  if ((32'(mem_rdata[3:0]) >= 32'(REG_COUNT)) ||
                      ((icode_ff != ICODE_IRMOVQ) &&
                       (32'(mem_rdata[7:4]) >= 32'(REG_COUNT)))) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in   = make_rsp(STAT_INS, pc_ff, 1'b0, 4'd0, 1'b0, 64'd0);
                     state_in = S_IDLE;
                  end else if (icode_ff == ICODE_RRMOVQ) begin
                     rf_raddr = mem_rdata[7:4];
                     state_in = S_MOVE;
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
               default: begin
                  valc_in = valc_shift;
                  if (idx_ff == 4'd9) begin
                     if (icode_ff == ICODE_IRMOVQ) begin
                        rf_wr.we   = 1'b1;
                        rf_wr.addr = rb_ff;
                        rf_wr.data = valc_shift;
                        pc_in      = pc_ff + LEN_LONG;
                        rsp_strobe_in = 1'b1;
                        rsp_in   = make_rsp(STAT_OK, pc_ff + LEN_LONG, 1'b1, rb_ff, 1'b0,
                                            valc_shift);
                        state_in = S_IDLE;
                     end else begin
                        rf_raddr = rb_ff;
                        state_in = S_ADDR;
                     end
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
            endcase
         end

         // rrmovq: the source register is on the read port.
         S_MOVE: begin
            rf_wr.we   = 1'b1;
            rf_wr.addr = rb_ff;
            rf_wr.data = rf_rdata;
            pc_in      = pc_ff + LEN_SHORT;
            rsp_strobe_in = 1'b1;
            rsp_in   = make_rsp(STAT_OK, pc_ff + LEN_SHORT, 1'b1, rb_ff, 1'b0, rf_rdata);
            state_in = S_IDLE;
         end

         // Effective address, wrapping at 64 bits.
         S_ADDR: begin
            addr_in  = valc_ff + rf_rdata;
            state_in = S_CHECK;
         end

         // All eight data bytes must lie inside memory without wrapping.
         S_CHECK: begin
            mem_raddr = MEM_ADDR_W'(addr_ff);
            idx_in    = 4'd0;
            if (addr_ff > 64'(MEM_BYTES - 8)) begin
               rsp_strobe_in = 1'b1;
               rsp_in   = make_rsp(STAT_ADR, pc_ff, 1'b0, 4'd0, 1'b0, 64'd0);
               state_in = S_IDLE;
            end else if (icode_ff == ICODE_RMMOVQ) begin
               rf_raddr = ra_ff;
               state_in = S_STORE_RD;
            end else begin
               state_in = S_LOAD;
            end
         end

         S_STORE_RD: begin
            val_in   = rf_rdata;
            idx_in   = 4'd0;
            state_in = S_STORE;
         end

         // rmmovq: one data byte written per cycle, lowest first.
         S_STORE: begin
            mem_wr.we   = 1'b1;
            mem_wr.addr = data_addr;
            mem_wr.data = val_ff[8*idx_ff[2:0] +: 8];
            if (idx_ff == 4'd7) begin
               pc_in    = pc_ff + LEN_LONG;
               rsp_strobe_in = 1'b1;
               rsp_in   = make_rsp(STAT_OK, pc_ff + LEN_LONG, 1'b0, 4'd0, 1'b1, val_ff);
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end

         // mrmovq: data byte idx on the read port, next one prefetched.
         S_LOAD: begin
            mem_raddr = data_addr + MEM_ADDR_W'(1);
            val_in    = load_shift;
            if (idx_ff == 4'd7) begin
               rf_wr.we   = 1'b1;
               rf_wr.addr = ra_ff;
               rf_wr.data = load_shift;
               pc_in      = pc_ff + LEN_LONG;
               rsp_strobe_in = 1'b1;
               rsp_in   = make_rsp(STAT_OK, pc_ff + LEN_LONG, 1'b1, ra_ff, 1'b0, load_shift);
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Every accepted request either is answered at once or keeps the unit busy.
   `Y86MV_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_strobe || busy, "request neither answered nor in progress")
   // A fault changes nothing and reports no moved data.
   `Y86MV_ASSERT_NOW(a_fault_clean, clock, reset, rsp_strobe && (rsp_data.status != STAT_OK), !rsp_data.reg_written && !rsp_data.mem_written && (rsp_data.moved_value == 64'sd0), "faulting response reports a write")
   // A register write names a real register and never comes with a store.
   `Y86MV_ASSERT_NOW(a_dest_valid, clock, reset, rsp_strobe && rsp_data.reg_written, (32'(rsp_data.dest_reg) < 32'(REG_COUNT)) && !rsp_data.mem_written, "bad destination register")

endmodule

>>> bench/y86_move_instruction_unit_core_tb.sv
`timescale 1ns / 1ps

module y86_move_instruction_unit_core_tb import y86mv_pkg::*; ();

   // One row of the directed table. Rows with typed set carry their answer inline.
   typedef struct {
      req_type         req;
      bit              typed;
      status_type      st;
      logic [PC_W-1:0] pc;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Shadow copy of the machine: memory, registers and program counter.
   logic [7:0]      mem_copy [MEM_BYTES];
   logic [63:0]     regs_copy [REG_COUNT];
   logic [PC_W-1:0] pc_copy;

   rsp_type outcomes_due [$];
   int      failures;
   int      idle_pct;
   int      items_sent;

   y86_move_instruction_unit_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Executes one request on the shadow machine and returns the response it should give.
   function automatic rsp_type step_machine(req_type r);
      rsp_type     res;
      logic [3:0]  icode;
      logic [3:0]  ra;
      logic [3:0]  rb;
      int unsigned pc;
      int unsigned len;
      logic [63:0] valc;
      logic [63:0] addr;
      logic [63:0] val;
      logic [63:0] byte_addr;
      int          i;
      res         = '0;
      res.status  = STAT_OK;
      res.next_pc = pc_copy;
      pc          = 32'(pc_copy);

      // A byte load always lands inside memory at this address width.
      if (r.op == OP_LOAD_BYTE) begin
         mem_copy[r.load_address] = r.load_byte;
         return res;
      end

      // Decode, in the order code, length, registers.
      icode = mem_copy[pc_copy][7:4];
      if (icode < ICODE_RRMOVQ || icode > ICODE_MRMOVQ) begin
         res.status = STAT_INS;
         return res;
      end
      len = (icode == ICODE_RRMOVQ) ? 32'd2 : 32'd10;
      if (pc + len > 32'(MEM_BYTES)) begin
         res.status = STAT_ADR;
         return res;
      end
      ra = mem_copy[pc_copy + PC_W'(1)][7:4];
      rb = mem_copy[pc_copy + PC_W'(1)][3:0];
      if (rb >= REG_IDX_W'(REG_COUNT) ||
          (icode != ICODE_IRMOVQ && ra >= REG_IDX_W'(REG_COUNT))) begin
         res.status = STAT_INS;
         return res;
      end
      valc = '0;
      if (len == 32'd10) begin
         for (i = 9; i >= 2; i--) valc = {valc[55:0], mem_copy[pc_copy + PC_W'(i)]};
      end

      val = '0;
      if (icode == ICODE_RRMOVQ || icode == ICODE_IRMOVQ) begin
         // Register destination moves.
         val             = (icode == ICODE_RRMOVQ) ? regs_copy[ra] : valc;
         regs_copy[rb]   = val;
         res.reg_written = 1'b1;
         res.dest_reg    = rb;
      end else begin
         // Every one of the eight data bytes must fall inside memory, without wrapping.
         addr = valc + regs_copy[rb];
         for (i = 0; i < 8; i++) begin
            byte_addr = addr + 64'(i);
            if (byte_addr >= 64'(MEM_BYTES)) begin
               res.status = STAT_ADR;
               return res;
            end
         end
         if (icode == ICODE_RMMOVQ) begin
            val = regs_copy[ra];
            for (i = 0; i < 8; i++) mem_copy[MEM_ADDR_W'(addr + 64'(i))] = val[8*i +: 8];
            res.mem_written = 1'b1;
         end else begin
            for (i = 7; i >= 0; i--) val = {val[55:0], mem_copy[MEM_ADDR_W'(addr + 64'(i))]};
            regs_copy[ra]   = val;
            res.reg_written = 1'b1;
            res.dest_reg    = ra;
         end
      end
      pc_copy         = PC_W'(pc + len);
      res.next_pc     = pc_copy;
      res.moved_value = val;
      return res;
   endfunction

   function automatic req_type make_req(logic op, int unsigned addr, int unsigned data);
      req_type r;
      r.op           = op;
      r.load_address = addr[11:0];
      r.load_byte    = data[7:0];
      return r;
   endfunction

   function automatic stim_row_type stim(logic op, int unsigned addr, int unsigned data,
                                         bit typed, status_type st, int unsigned pc);
      stim_row_type row;
      row.req   = make_req(op, addr, data);
      row.typed = typed;
      row.st    = st;
      row.pc    = pc[11:0];
      return row;
   endfunction

   // Presents one request, waits until it is taken and records the response it owes.
   task automatic issue_request(req_type r, bit typed, status_type st, logic [PC_W-1:0] pc);
      rsp_type owed;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      owed = step_machine(r);
      if (typed) begin
         owed         = '0;
         owed.status  = st;
         owed.next_pc = pc;
      end
      outcomes_due.push_back(owed);
      items_sent++;
   endtask

   // Writes a two-byte header at the program counter and executes it.
   task automatic two_byte_step(logic [3:0] icode);
      issue_request(make_req(OP_LOAD_BYTE, 32'(pc_copy),
                             32'({icode, 4'($urandom_range(15))})),
                    1'b0, STAT_OK, '0);
      issue_request(make_req(OP_LOAD_BYTE, 32'(pc_copy) + 32'd1,
                             32'({4'($urandom_range(14)), 4'($urandom_range(14))})),
                    1'b0, STAT_OK, '0);
      issue_request(make_req(OP_EXECUTE, $urandom, $urandom), 1'b0, STAT_OK, '0);
   endtask

   // Walks the program counter up to the top of memory, faults there, and wraps to zero when it stops at 4094.
   task automatic run_to_memory_end();
      while (32'(pc_copy) + 32'd10 <= 32'd4094) two_byte_step(ICODE_IRMOVQ);
      two_byte_step(ICODE_IRMOVQ);
      while (32'(pc_copy) > 32'd2048 && 32'(pc_copy) < 32'd4094) begin
         two_byte_step(ICODE_RRMOVQ);
      end
      if (pc_copy == PC_W'(4094)) begin
         two_byte_step(ICODE_IRMOVQ);
         two_byte_step(ICODE_RRMOVQ);
      end
   endtask

   // One random sequence: mostly a whole instruction laid at the program counter and run.
   task automatic random_sequence();
      int unsigned pick;
      logic [3:0]  icode;
      logic [3:0]  ra;
      logic [3:0]  rb;
      logic [63:0] valc;
      logic [63:0] target;
      logic [7:0]  code [10];
      int          len;
      int          i;
      pick = $urandom_range(99);

      // Stray byte load anywhere in memory.
      if (pick < 12) begin
         issue_request(make_req(OP_LOAD_BYTE, $urandom_range(4095), $urandom_range(255)),
                       1'b0, STAT_OK, '0);
         return;
      end

      // Execute whatever happens to sit at the program counter.
      if (pick < 20) begin
         issue_request(make_req(OP_EXECUTE, $urandom, $urandom), 1'b0, STAT_OK, '0);
         return;
      end

      icode = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                       : 4'(ICODE_RRMOVQ + $urandom_range(3));
      ra = ($urandom_range(15) == 0) ? 4'hF : 4'($urandom_range(REG_COUNT - 1));
      rb = ($urandom_range(15) == 0) ? 4'hF : 4'($urandom_range(REG_COUNT - 1));
      case ($urandom_range(7))
         0: valc = '0;
         1: valc = '1;
         2: valc = 64'h8000_0000_0000_0000;
         3: valc = 64'h7FFF_FFFF_FFFF_FFFF;
         default: valc = {$urandom, $urandom};
      endcase

      // Memory moves mostly aim at a chosen effective address, some near or past the top.
      if ((icode == ICODE_RMMOVQ || icode == ICODE_MRMOVQ) && rb != 4'hF) begin
         case ($urandom_range(9))
            7: target = 64'(4080 + $urandom_range(15));
            8: target = valc;
            9: target = 64'hFFFF_FFFF_FFFF_FFF8 + 64'($urandom_range(7));
            default: target = 64'($urandom_range(4088));
         endcase
         valc = target - regs_copy[rb];
      end

      len = (icode >= ICODE_IRMOVQ && icode <= ICODE_MRMOVQ) ? 10 : 2;
      code[0] = {icode, 4'($urandom_range(15))};
      code[1] = {ra, rb};
      for (i = 0; i < 8; i++) code[i + 2] = valc[8*i +: 8];

      // Now and then the instruction is left incomplete before it runs.
      if ($urandom_range(9) == 0) len = int'($urandom_range(len - 1));
      for (i = 0; i < len; i++) begin
         issue_request(make_req(OP_LOAD_BYTE, 32'(pc_copy) + 32'(i), 32'(code[i])),
                       1'b0, STAT_OK, '0);
      end
      issue_request(make_req(OP_EXECUTE, $urandom, $urandom), 1'b0, STAT_OK, '0);
   endtask

   // Response checker: each strobe is matched against the oldest owed response.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (outcomes_due.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.next_pc !== want.next_pc) begin
               $error("next_pc expected %0d got %0d", want.next_pc, rsp_data.next_pc);
               failures++;
            end
            if (rsp_data.reg_written !== want.reg_written) begin
               $error("reg_written expected %0b got %0b", want.reg_written,
                      rsp_data.reg_written);
               failures++;
            end
            if (rsp_data.dest_reg !== want.dest_reg) begin
               $error("dest_reg expected %0d got %0d", want.dest_reg, rsp_data.dest_reg);
               failures++;
            end
            if (rsp_data.mem_written !== want.mem_written) begin
               $error("mem_written expected %0b got %0b", want.mem_written,
                      rsp_data.mem_written);
               failures++;
            end
            if (rsp_data.moved_value !== want.moved_value) begin
               $error("moved_value expected %h got %h", want.moved_value,
                      rsp_data.moved_value);
               failures++;
            end
         end
      end
   end

   // Stimulus: directed table, then four phases of random sequences.
   initial begin
      stim_row_type directed [$];
      int           idle_plan [4];
      int           phase;
      int           k;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      failures   = 0;
      idle_pct   = 0;
      items_sent = 0;
      idle_plan  = '{0, 68, 0, 12};
      mem_copy   = '{default: 8'd0};
      regs_copy  = '{default: 64'd0};
      pc_copy    = '0;

      // Empty memory decodes as an unknown code; the top byte takes the widest load.
      directed.push_back(stim(OP_EXECUTE, 'hFFF, 'hFF, 1'b1, STAT_INS, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 4095, 'hFF, 1'b1, STAT_OK, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 0, 'hF0, 1'b1, STAT_OK, 0));
      directed.push_back(stim(OP_EXECUTE, 0, 0, 1'b1, STAT_INS, 0));
      // rrmovq with rA of 15, then with rB of 15.
      directed.push_back(stim(OP_LOAD_BYTE, 0, 'h20, 1'b1, STAT_OK, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 1, 'hF1, 1'b1, STAT_OK, 0));
      directed.push_back(stim(OP_EXECUTE, 0, 0, 1'b1, STAT_INS, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 1, 'h1F, 1'b1, STAT_OK, 0));
      directed.push_back(stim(OP_EXECUTE, 0, 0, 1'b1, STAT_INS, 0));
      // irmovq ignores its rA of 15 and loads the most negative constant into r2.
      directed.push_back(stim(OP_LOAD_BYTE, 0, 'h30, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 1, 'hF2, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 9, 'h80, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_EXECUTE, 0, 0, 1'b0, STAT_OK, 0));
      // rrmovq r2 to r14.
      directed.push_back(stim(OP_LOAD_BYTE, 10, 'h20, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 11, 'h2E, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_EXECUTE, 0, 0, 1'b0, STAT_OK, 0));
      // rmmovq through r2 lands far outside memory.
      directed.push_back(stim(OP_LOAD_BYTE, 12, 'h40, 1'b1, STAT_OK, 12));
      directed.push_back(stim(OP_LOAD_BYTE, 13, 'hE2, 1'b1, STAT_OK, 12));
      directed.push_back(stim(OP_EXECUTE, 0, 0, 1'b1, STAT_ADR, 12));
      // mrmovq from address zero into r14.
      directed.push_back(stim(OP_LOAD_BYTE, 12, 'h50, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 13, 'hE1, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_EXECUTE, 0, 0, 1'b0, STAT_OK, 0));
      // rmmovq into the last eight bytes of memory.
      directed.push_back(stim(OP_LOAD_BYTE, 22, 'h40, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 23, 'hE1, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 24, 'hF8, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_LOAD_BYTE, 25, 'h0F, 1'b0, STAT_OK, 0));
      directed.push_back(stim(OP_EXECUTE, 0, 0, 1'b0, STAT_OK, 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < directed.size(); k++) begin
         issue_request(directed[k].req, directed[k].typed, directed[k].st, directed[k].pc);
      end

      // The response side takes no back-pressure, so the phases vary only the sender's idle percentage.
      // The walk to the top of memory adds roughly a thousand requests of its own.
      for (phase = 0; phase < 4; phase++) begin
         idle_pct   = idle_plan[phase];
         items_sent = 0;
         while (items_sent < 140) random_sequence();
         if (phase == 1) run_to_memory_end();
      end
      start <= 1'b0;

      // Drain the owed responses, then give the block time to show any extra strobe.
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0 && outcomes_due.size() == 0) begin
         $display("y86_move_instruction_unit_core: match");
      end else begin
         $display("y86_move_instruction_unit_core: mismatch");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("y86_move_instruction_unit_core: mismatch");
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/y86mv_pkg.sv
sv/y86mv_byte_ram.sv
sv/y86mv_reg_file.sv
sv/y86_move_instruction_unit_core.sv
bench/y86_move_instruction_unit_core_tb.sv
